// ===== hdl/jddc_pkg.sv =====
// ============================================================================
// jddc_pkg: shared definitions of the Julian day / date converter
// Field layout of the stream beats, the command codes, the reciprocal
// constants that replace division by constants, and two small month tables.
// ============================================================================
package jddc_pkg;

   // Number of pipeline register stages in front of the output register.
   localparam int NumStages = 6;

   // Beat layout, shared by the request and the response channel.
   localparam int DataWidth     = 72;
   localparam int YearWidth     = 14;
   localparam int MonthWidth    = 4;
   localparam int DayWidth      = 5;
   localparam int HourWidth     = 5;
   localparam int MinuteWidth   = 6;
   localparam int DayNumWidth   = 23;
   localparam int MinOfDayWidth = 11;

   localparam int YearLsb     = 0;
   localparam int MonthLsb    = YearLsb + YearWidth;
   localparam int DayLsb      = MonthLsb + MonthWidth;
   localparam int HourLsb     = DayLsb + DayWidth;
   localparam int MinuteLsb   = HourLsb + HourWidth;
   localparam int DayNumLsb   = MinuteLsb + MinuteWidth;
   localparam int MinOfDayLsb = DayNumLsb + DayNumWidth;

   typedef enum logic {
      CmdDateToJd = 1'b0,
      CmdJdToDate = 1'b1
   } command_type;

   // Calendar constants.
   localparam int MinutesPerHour = 60;
   localparam int MinutesPerDay  = 1440;
   localparam int March          = 3;
   localparam int MonthsPerYear  = 12;
   localparam int QuadYearDays   = 1461;
   localparam int EraDays        = 146097;
   localparam int YearBias       = 400;     // keeps the shifted year positive
   localparam int EpochYears     = 4316;    // 4716 less the year bias
   localparam int DateBias       = 1519;    // 1524 less the century terms bias
   localparam int JdOffset       = 68569;
   localparam int DayBias        = 31;
   localparam int CenturyBase    = 4900;    // 100 * 49
   localparam int YearsPerCent   = 100;
   localparam int LateMonthIdx   = 11;

   // floor(a * Num / Den) is computed as (a * Mul) >> Shift with
   // Mul = ceil(Num * 2^Shift / Den); it is exact while a * error < 2^Shift.

   // Year / 100, year below 2^15.
   localparam int HundredShift = 22;
   localparam longint unsigned HundredMulL = ((64'd1 << HundredShift) + 64'd99) / 64'd100;
   localparam int HundredMulW = $clog2(HundredMulL + 64'd1);
   localparam logic [HundredMulW-1:0] HundredMul = HundredMulW'(HundredMulL);

   // 4 * s / 146097, s below 2^24.
   localparam int EraShift = 42;
   localparam longint unsigned EraMulL = ((64'd4 << EraShift) + 64'd146096) / 64'd146097;
   localparam int EraMulW = $clog2(EraMulL + 64'd1);
   localparam logic [EraMulW-1:0] EraMul = EraMulW'(EraMulL);

   // 4000 * s / 1461001, s below 2^16.
   localparam int YearShift = 37;
   localparam longint unsigned YearMulL =
      ((64'd4000 << YearShift) + 64'd1461000) / 64'd1461001;
   localparam int YearMulW = $clog2(YearMulL + 64'd1);
   localparam logic [YearMulW-1:0] YearMul = YearMulW'(YearMulL);

   // 80 * s / 2447, s below 2^9.
   localparam int MonthShift = 21;
   localparam longint unsigned MonthMulL = ((64'd80 << MonthShift) + 64'd2446) / 64'd2447;
   localparam int MonthMulW = $clog2(MonthMulL + 64'd1);
   localparam logic [MonthMulW-1:0] MonthMul = MonthMulW'(MonthMulL);

   // Minutes / 60, minutes below 2^11.
   localparam int HourShift = 17;
   localparam longint unsigned HourMulL = ((64'd1 << HourShift) + 64'd59) / 64'd60;
   localparam int HourMulW = $clog2(HourMulL + 64'd1);
   localparam logic [HourMulW-1:0] HourMul = HourMulW'(HourMulL);

   // Days before the month in a March-based year: floor(153 * (m + 1) / 5).
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] r;
      unique case (m)
         4'd0:    r = 9'd30;
         4'd1:    r = 9'd61;
         4'd2:    r = 9'd91;
         4'd3:    r = 9'd122;
         4'd4:    r = 9'd153;
         4'd5:    r = 9'd183;
         4'd6:    r = 9'd214;
         4'd7:    r = 9'd244;
         4'd8:    r = 9'd275;
         4'd9:    r = 9'd306;
         4'd10:   r = 9'd336;
         4'd11:   r = 9'd367;
         4'd12:   r = 9'd397;
         4'd13:   r = 9'd428;
         4'd14:   r = 9'd459;
         default: r = 9'd489;
      endcase
      return r;
   endfunction

   // Days before month index q: floor(2447 * q / 80).
   function automatic logic [8:0] day_offset(input logic [3:0] q);
      logic [8:0] r;
      unique case (q)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd30;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd91;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd152;
         4'd6:    r = 9'd183;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd244;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd305;
         4'd11:   r = 9'd336;
         4'd12:   r = 9'd367;
         4'd13:   r = 9'd397;
         4'd14:   r = 9'd428;
         default: r = 9'd458;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/jddc_date_to_jd.sv =====
// ============================================================================
// jddc_date_to_jd: date and time to Julian day number, pipelined
// Six register stages; the day number is ready after the fourth and is
// delayed to line up with the other direction.
// ============================================================================
module jddc_date_to_jd (
   input  logic                           clock,
   input  logic [jddc_pkg::NumStages-1:0] stage_load,
   input  logic [13:0]                    year,
   input  logic [3:0]                     month,
   input  logic [4:0]                     day,
   input  logic [4:0]                     hour,
   input  logic [5:0]                     minute,
   output logic [22:0]                    day_number,
   output logic [10:0]                    minute_of_day
);

   // Stage 0: month shift, biased year, minutes of the day.
   logic        early_in;
   logic [3:0]  mon_in;
   logic [14:0] yp_in;
   logic [10:0] tmin_in;
   logic [3:0]  mon_ff;
   logic [14:0] yp_ff;
   logic [4:0]  day0_ff;
   logic [10:0] tmin0_ff;

   // Stage 1: century count, year days, month days, day carry.
   logic [15+jddc_pkg::HundredMulW-1:0] hund_prod;
   logic [14:0] ysum;
   logic [24:0] quad_prod;
   logic [7:0]  q100_in;
   logic [22:0] ydays_in;
   logic        carry_in;
   logic [10:0] tmin1_in;
   logic [7:0]  q100_1_ff;
   logic [22:0] ydays_ff;
   logic [8:0]  mdays_ff;
   logic [4:0]  day1_ff;
   logic        carry_ff;
   logic [10:0] tmin1_ff;

   // Stage 2 and 3: two halves of the final sum, then delay stages.
   logic [22:0] sum_in;
   logic [22:0] sum_ff;
   logic [7:0]  q100_2_ff;
   logic [10:0] tmin2_ff;
   logic [22:0] jdn_in;
   logic [22:0] jdn3_ff;
   logic [22:0] jdn4_ff;
   logic [22:0] jdn5_ff;
   logic [10:0] tmin3_ff;
   logic [10:0] tmin4_ff;
   logic [10:0] tmin5_ff;

   always_comb begin
      early_in = (month < 4'(jddc_pkg::March));
      mon_in   = early_in ? 4'(month + 4'(jddc_pkg::MonthsPerYear)) : month;
      yp_in    = 15'(year) + 15'(jddc_pkg::YearBias) - 15'(early_in);
      tmin_in  = 11'(hour) * 11'(jddc_pkg::MinutesPerHour) + 11'(minute);
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         mon_ff   <= mon_in;
         yp_ff    <= yp_in;
         day0_ff  <= day;
         tmin0_ff <= tmin_in;
      end
   end

   always_comb begin
      hund_prod = (15+jddc_pkg::HundredMulW)'(yp_ff) *
                  (15+jddc_pkg::HundredMulW)'(jddc_pkg::HundredMul);
      q100_in   = hund_prod[jddc_pkg::HundredShift +: 8];
      ysum      = yp_ff + 15'(jddc_pkg::EpochYears);
      quad_prod = 25'(ysum) * 25'(jddc_pkg::QuadYearDays);
      ydays_in  = quad_prod[24:2];
      carry_in  = (tmin0_ff >= 11'(jddc_pkg::MinutesPerDay));
      tmin1_in  = carry_in ? tmin0_ff - 11'(jddc_pkg::MinutesPerDay) : tmin0_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         q100_1_ff <= q100_in;
         ydays_ff  <= ydays_in;
         mdays_ff  <= jddc_pkg::month_offset(mon_ff);
         day1_ff   <= day0_ff;
         carry_ff  <= carry_in;
         tmin1_ff  <= tmin1_in;
      end
   end

   assign sum_in = ydays_ff + 23'(mdays_ff) + 23'(day1_ff) + 23'(carry_ff);

   always_ff @(posedge clock) begin
      if (stage_load[2]) begin
         sum_ff    <= sum_in;
         q100_2_ff <= q100_1_ff;
         tmin2_ff  <= tmin1_ff;
      end
   end

   // Gregorian correction: the century count out, the 400-year count back in.
   assign jdn_in = sum_ff - 23'(q100_2_ff) + 23'(q100_2_ff[7:2]) - 23'(jddc_pkg::DateBias);

   always_ff @(posedge clock) begin
      if (stage_load[3]) begin
         jdn3_ff  <= jdn_in;
         tmin3_ff <= tmin2_ff;
      end
      if (stage_load[4]) begin
         jdn4_ff  <= jdn3_ff;
         tmin4_ff <= tmin3_ff;
      end
      if (stage_load[5]) begin
         jdn5_ff  <= jdn4_ff;
         tmin5_ff <= tmin4_ff;
      end
   end

   assign day_number    = jdn5_ff;
   assign minute_of_day = tmin5_ff;

endmodule

// ===== hdl/jddc_jd_to_date.sv =====
// ============================================================================
// jddc_jd_to_date: Julian day number to date and time, pipelined
// Integer calendar steps, with the constant multiplies spread over the stages; the last step
// (month, day, year assembly) is left to the output register of the caller.
// ============================================================================
module jddc_jd_to_date (
   input  logic                           clock,
   input  logic [jddc_pkg::NumStages-1:0] stage_load,
   input  logic [22:0]                    day_number,
   input  logic [10:0]                    minute_of_day,
   output logic [13:0]                    out_year,
   output logic [3:0]                     out_month,
   output logic [4:0]                     out_day,
   output logic [4:0]                     out_hour,
   output logic [5:0]                     out_minute
);

   // Stage 0
   logic        carry_in;
   logic [10:0] mod_in;
   logic [23:0] s1_in;
   logic [23:0] s1_0_ff;
   logic [10:0] mod0_ff;
   // Stage 1
   logic [24+jddc_pkg::EraMulW-1:0]  era_prod;
   logic [11+jddc_pkg::HourMulW-1:0] hour_prod;
   logic [23:0] s1_1_ff;
   logic [10:0] mod1_ff;
   logic [7:0]  n1_ff;
   logic [4:0]  hour1_ff;
   // Stage 2
   logic [25:0] era_days;
   logic [25:0] era_round;
   logic [15:0] s2_in;
   logic [5:0]  minute_in;
   logic [15:0] s2_2_ff;
   logic [7:0]  n2_ff;
   logic [4:0]  hour2_ff;
   logic [5:0]  minute2_ff;
   // Stage 3
   logic [15:0] s2_inc;
   logic [16+jddc_pkg::YearMulW-1:0] year_prod;
   logic [15:0] s2_3_ff;
   logic [6:0]  i3_ff;
   logic [7:0]  n3_ff;
   logic [4:0]  hour3_ff;
   logic [5:0]  minute3_ff;
   // Stage 4
   logic [17:0] quad_prod;
   logic [8:0]  s3_in;
   logic [8:0]  s3_4_ff;
   logic [6:0]  i4_ff;
   logic [7:0]  n4_ff;
   logic [4:0]  hour4_ff;
   logic [5:0]  minute4_ff;
   // Stage 5
   logic [9+jddc_pkg::MonthMulW-1:0] month_prod;
   logic [3:0]  q5_ff;
   logic [8:0]  s3_5_ff;
   logic [6:0]  i5_ff;
   logic [7:0]  n5_ff;
   logic [4:0]  hour5_ff;
   logic [5:0]  minute5_ff;
   // Final assembly
   logic        late;
   logic [8:0]  day_full;

   always_comb begin
      carry_in = (minute_of_day >= 11'(jddc_pkg::MinutesPerDay));
      mod_in   = carry_in ? minute_of_day - 11'(jddc_pkg::MinutesPerDay) : minute_of_day;
      s1_in    = 24'(day_number) + 24'(carry_in) + 24'(jddc_pkg::JdOffset);
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         s1_0_ff <= s1_in;
         mod0_ff <= mod_in;
      end
   end

   always_comb begin
      era_prod  = (24+jddc_pkg::EraMulW)'(s1_0_ff) * (24+jddc_pkg::EraMulW)'(jddc_pkg::EraMul);
      hour_prod = (11+jddc_pkg::HourMulW)'(mod0_ff) *
                  (11+jddc_pkg::HourMulW)'(jddc_pkg::HourMul);
   end

   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         s1_1_ff  <= s1_0_ff;
         mod1_ff  <= mod0_ff;
         n1_ff    <= era_prod[jddc_pkg::EraShift +: 8];
         hour1_ff <= hour_prod[jddc_pkg::HourShift +: 5];
      end
   end

   always_comb begin
      era_days  = 26'(n1_ff) * 26'(jddc_pkg::EraDays);
      era_round = era_days + 26'd3;
      s2_in     = 16'(s1_1_ff - era_round[25:2]);
      minute_in = 6'(mod1_ff - 11'(hour1_ff) * 11'(jddc_pkg::MinutesPerHour));
   end

   always_ff @(posedge clock) begin
      if (stage_load[2]) begin
         s2_2_ff    <= s2_in;
         n2_ff      <= n1_ff;
         hour2_ff   <= hour1_ff;
         minute2_ff <= minute_in;
      end
   end

   always_comb begin
      s2_inc    = s2_2_ff + 16'd1;
      year_prod = (16+jddc_pkg::YearMulW)'(s2_inc) * (16+jddc_pkg::YearMulW)'(jddc_pkg::YearMul);
   end

   always_ff @(posedge clock) begin
      if (stage_load[3]) begin
         s2_3_ff    <= s2_2_ff;
         i3_ff      <= year_prod[jddc_pkg::YearShift +: 7];
         n3_ff      <= n2_ff;
         hour3_ff   <= hour2_ff;
         minute3_ff <= minute2_ff;
      end
   end

   // The remainder of the year in days stays within a few hundred.
   always_comb begin
      quad_prod = 18'(i3_ff) * 18'(jddc_pkg::QuadYearDays);
      s3_in     = 9'(17'(s2_3_ff) + 17'(jddc_pkg::DayBias) - 17'(quad_prod[17:2]));
   end

   always_ff @(posedge clock) begin
      if (stage_load[4]) begin
         s3_4_ff    <= s3_in;
         i4_ff      <= i3_ff;
         n4_ff      <= n3_ff;
         hour4_ff   <= hour3_ff;
         minute4_ff <= minute3_ff;
      end
   end

   assign month_prod = (9+jddc_pkg::MonthMulW)'(s3_4_ff) *
                       (9+jddc_pkg::MonthMulW)'(jddc_pkg::MonthMul);

   always_ff @(posedge clock) begin
      if (stage_load[5]) begin
         q5_ff      <= month_prod[jddc_pkg::MonthShift +: 4];
         s3_5_ff    <= s3_4_ff;
         i5_ff      <= i4_ff;
         n5_ff      <= n4_ff;
         hour5_ff   <= hour4_ff;
         minute5_ff <= minute4_ff;
      end
   end

   // Month indexes eleven and up are January and February of the next year.
   always_comb begin
      late       = (q5_ff >= 4'(jddc_pkg::LateMonthIdx));
      day_full   = s3_5_ff - jddc_pkg::day_offset(q5_ff);
      out_day    = day_full[4:0];
      out_month  = late ? 4'(q5_ff + 4'd2 - 4'(jddc_pkg::MonthsPerYear)) : 4'(q5_ff + 4'd2);
      out_year   = 14'(15'(n5_ff) * 15'(jddc_pkg::YearsPerCent)) -
                   14'(jddc_pkg::CenturyBase) + 14'(i5_ff) + 14'(late);
      out_hour   = hour5_ff;
      out_minute = minute5_ff;
   end

endmodule

// ===== hdl/julian_day_date_converter_unit.sv =====
// ============================================================================
// julian_day_date_converter_unit: Gregorian date <-> Julian date converter
// Stream-in, stream-out converter between a calendar date with time of day
// and a Julian date held as a noon-based day number plus minutes.
// ============================================================================
// The unit converts one request beat into exactly one response beat, in
// order. The tuser bit of a request picks the direction: 0 turns year, month,
// day, hour and minute into a noon-based day number and a minute of day
// (JD = day_number - 0.5 + minute_of_day / 1440); 1 turns a day number and
// minute of day back into a Gregorian date with hour and minute. The fields
// of the direction not chosen read as zero in the response. Inputs are not
// checked: months 0 and 13 to 15, day 0 or times past midnight run through
// the same formulas, a minute count of a day or more carries into the day,
// and a year outside 0..16383 wraps in 14 bits. The unit takes a new beat
// every clock cycle while the consumer is ready. Every beat passes six
// pipeline stages and the output register, which presents the response;
// that depth is set by the Julian-to-date chain of constant multiplications.
// Back pressure stalls only the stages that are full, so empty slots are
// squeezed out and up to seven beats are held inside the unit.
// ============================================================================
module julian_day_date_converter_unit (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28],
   // day_number[56:34], minute_of_day[67:57], zero[71:68]
   input  logic [jddc_pkg::DataWidth-1:0] req_tdata,
   // command[0]
   input  logic [0:0]                     req_tuser,
   // Response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_year[13:0], out_month[17:14], out_day[22:18], out_hour[27:23],
   // out_minute[33:28], out_day_number[56:34], out_minute_of_day[67:57],
   // zero[71:68]
   output logic [jddc_pkg::DataWidth-1:0] rsp_tdata
);

   localparam int N = jddc_pkg::NumStages;

   logic [N-1:0]          stage_load;
   logic                  out_load;
   logic [N-1:0]          valid_ff;
   jddc_pkg::command_type cmd_ff [N];
   logic                  rsp_valid_ff;
   logic [jddc_pkg::DataWidth-1:0] rsp_data_ff;
   logic [jddc_pkg::DataWidth-1:0] rsp_data_in;

   logic [22:0] jd_day_number;
   logic [10:0] jd_minute_of_day;
   logic [13:0] dt_year;
   logic [3:0]  dt_month;
   logic [4:0]  dt_day;
   logic [4:0]  dt_hour;
   logic [5:0]  dt_minute;

   // A stage takes new data when it is empty or when the stage after it
   // moves on; the output register moves when empty or when its beat leaves.
   always_comb begin
      out_load         = !rsp_valid_ff || rsp_tready;
      stage_load[N-1]  = !valid_ff[N-1] || out_load;
      for (int k = N - 2; k >= 0; k--) begin
         stage_load[k] = !valid_ff[k] || stage_load[k+1];
      end
   end

   assign req_tready = stage_load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (stage_load[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < N; k++) begin
            if (stage_load[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
         if (out_load) begin
            rsp_valid_ff <= valid_ff[N-1];
         end
      end
   end

   // The command travels beside the data so the output knows which half
   // of the beat to fill.
   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         cmd_ff[0] <= jddc_pkg::command_type'(req_tuser[0]);
      end
      for (int k = 1; k < N; k++) begin
         if (stage_load[k]) begin
            cmd_ff[k] <= cmd_ff[k-1];
         end
      end
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Both directions run on every beat; the command selects the result.
   jddc_date_to_jd u_date_to_jd (
      .clock         (clock),
      .stage_load    (stage_load),
      .year          (req_tdata[jddc_pkg::YearLsb +: jddc_pkg::YearWidth]),
      .month         (req_tdata[jddc_pkg::MonthLsb +: jddc_pkg::MonthWidth]),
      .day           (req_tdata[jddc_pkg::DayLsb +: jddc_pkg::DayWidth]),
      .hour          (req_tdata[jddc_pkg::HourLsb +: jddc_pkg::HourWidth]),
      .minute        (req_tdata[jddc_pkg::MinuteLsb +: jddc_pkg::MinuteWidth]),
      .day_number    (jd_day_number),
      .minute_of_day (jd_minute_of_day)
   );

   jddc_jd_to_date u_jd_to_date (
      .clock         (clock),
      .stage_load    (stage_load),
      .day_number    (req_tdata[jddc_pkg::DayNumLsb +: jddc_pkg::DayNumWidth]),
      .minute_of_day (req_tdata[jddc_pkg::MinOfDayLsb +: jddc_pkg::MinOfDayWidth]),
      .out_year      (dt_year),
      .out_month     (dt_month),
      .out_day       (dt_day),
      .out_hour      (dt_hour),
      .out_minute    (dt_minute)
   );

   always_comb begin
      rsp_data_in = '0;
      if (cmd_ff[N-1] == jddc_pkg::CmdJdToDate) begin
         rsp_data_in[jddc_pkg::YearLsb +: jddc_pkg::YearWidth]     = dt_year;
         rsp_data_in[jddc_pkg::MonthLsb +: jddc_pkg::MonthWidth]   = dt_month;
         rsp_data_in[jddc_pkg::DayLsb +: jddc_pkg::DayWidth]       = dt_day;
         rsp_data_in[jddc_pkg::HourLsb +: jddc_pkg::HourWidth]     = dt_hour;
         rsp_data_in[jddc_pkg::MinuteLsb +: jddc_pkg::MinuteWidth] = dt_minute;
      end else begin
         rsp_data_in[jddc_pkg::DayNumLsb +: jddc_pkg::DayNumWidth]     = jd_day_number;
         rsp_data_in[jddc_pkg::MinOfDayLsb +: jddc_pkg::MinOfDayWidth] = jd_minute_of_day;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== tb/tb_julian_day_date_converter_unit.sv =====
// ============================================================================
// tb_julian_day_date_converter_unit: self-checking bench of the date converter
// Streams calendar dates and Julian day numbers through the converter under
// several pacing patterns and checks every response beat against a typed-in
// answer or an in-bench calculation of the same integer conversion.
// ============================================================================
module tb_julian_day_date_converter_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // The unit holds at most seven beats; the drain margin and the watchdog limit
   // are both taken well above that figure.
   localparam int DrainCycles  = 24;
   localparam int StallLimit   = 2000;
   localparam int RandomBeats  = 1500;
   localparam int PaceBlock    = 125;
   localparam int ReportLimit  = 10;

   // Both channels share one field layout, so a single packed struct covers a
   // request beat and a response beat. The last field sits in the low bits.
   typedef struct packed {
      logic [jddc_pkg::MinOfDayWidth-1:0] minute_of_day;
      logic [jddc_pkg::DayNumWidth-1:0]   day_number;
      logic [jddc_pkg::MinuteWidth-1:0]   minute;
      logic [jddc_pkg::HourWidth-1:0]     hour;
      logic [jddc_pkg::DayWidth-1:0]      day;
      logic [jddc_pkg::MonthWidth-1:0]    month;
      logic [jddc_pkg::YearWidth-1:0]     year;
   } cal_fields_type;

   // One row of the directed table. Rows with a pinned result carry their
   // answer typed in; all others are worked out by convert_calendar.
   typedef struct {
      jddc_pkg::command_type cmd;
      cal_fields_type        request;
      bit                    pinned;
      cal_fields_type        answer;
   } stim_row_type;

   typedef enum int {
      PaceFull,
      PaceSenderIdle,
      PaceReceiverStall,
      PaceBothIdle
   } pace_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [jddc_pkg::DataWidth-1:0] req_tdata = '0;
   logic [0:0]                     req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b1;
   logic [jddc_pkg::DataWidth-1:0] rsp_tdata;

   // Travels with the request beat so that the checker sees which answer
   // belongs to it at the very edge where the beat is taken.
   bit             beat_pinned = 1'b0;
   cal_fields_type beat_answer = '0;

   cal_fields_type awaited_conversions[$];
   stim_row_type   directed_rows[$];
   int             mismatches  = 0;
   int             idle_cycles = 0;
   int             tx_idle_pct = 0;
   int             rx_stall_pct = 0;

   julian_day_date_converter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Division that rounds toward minus infinity, needed once the shifted year
   // goes negative (year zero in January or February).
   function automatic longint floor_quotient(input longint a, input longint b);
      if (a >= 0) return a / b;
      return -((-a + b - 1) / b);
   endfunction

   // Expected response for one request beat. The date direction counts
   // January and February as months 13 and 14 of the year before and adds the
   // Gregorian century correction; the Julian direction follows the
   // Fliegel-Van Flandern integer steps. All arithmetic is in 64-bit signed
   // integers and the results are cut to the field widths, so a year outside
   // the 14-bit range wraps just as the unit's output does.
   function automatic cal_fields_type convert_calendar(input jddc_pkg::command_type cmd,
                                                       input cal_fields_type rq);
      cal_fields_type r;
      longint y, m, d, tmin, corr, jdn;
      longint p, mod, s1, n, s2, i, s3, q, e, s4, mon, yr;
      r = '0;
      if (cmd == jddc_pkg::CmdDateToJd) begin
         y    = longint'(rq.year);
         m    = longint'(rq.month);
         d    = longint'(rq.day);
         tmin = longint'(rq.hour) * 60 + longint'(rq.minute);
         if (m < 3) begin
            m += 12;
            y -= 1;
         end
         corr = 2 - floor_quotient(y, 100) + floor_quotient(y, 400);
         jdn  = floor_quotient(1461 * (y + 4716), 4) + (153 * (m + 1)) / 5
                + d + corr - 1524;
         // Time of a day or more carries whole days into the day number.
         jdn += tmin / 1440;
         r.day_number    = (jddc_pkg::DayNumWidth)'(jdn);
         r.minute_of_day = (jddc_pkg::MinOfDayWidth)'(tmin % 1440);
      end else begin
         p   = longint'(rq.day_number);
         mod = longint'(rq.minute_of_day);
         p  += mod / 1440;
         mod = mod % 1440;
         s1  = p + 68569;
         n   = (4 * s1) / 146097;
         s2  = s1 - (146097 * n + 3) / 4;
         i   = (4000 * (s2 + 1)) / 1461001;
         s3  = s2 - (1461 * i) / 4 + 31;
         q   = (80 * s3) / 2447;
         e   = s3 - (2447 * q) / 80;
         s4  = q / 11;
         mon = q + 2 - 12 * s4;
         yr  = 100 * (n - 49) + i + s4;
         r.year   = (jddc_pkg::YearWidth)'(yr);
         r.month  = (jddc_pkg::MonthWidth)'(mon);
         r.day    = (jddc_pkg::DayWidth)'(e);
         r.hour   = (jddc_pkg::HourWidth)'(mod / 60);
         r.minute = (jddc_pkg::MinuteWidth)'(mod % 60);
      end
      return r;
   endfunction

   function automatic cal_fields_type fields(input int yr, input int mo, input int dd,
                                             input int hh, input int mi, input int dn,
                                             input int md);
      cal_fields_type f;
      f.year          = (jddc_pkg::YearWidth)'(yr);
      f.month         = (jddc_pkg::MonthWidth)'(mo);
      f.day           = (jddc_pkg::DayWidth)'(dd);
      f.hour          = (jddc_pkg::HourWidth)'(hh);
      f.minute        = (jddc_pkg::MinuteWidth)'(mi);
      f.day_number    = (jddc_pkg::DayNumWidth)'(dn);
      f.minute_of_day = (jddc_pkg::MinOfDayWidth)'(md);
      return f;
   endfunction

   // About half of the random beats stay inside the documented ranges, the
   // others use the full width of every field. The fields of the direction not
   // chosen are always filled with random values, which the unit has to ignore.
   function automatic cal_fields_type random_fields(input bit in_range);
      cal_fields_type f;
      logic [95:0]    noise;
      noise = {$urandom, $urandom, $urandom};
      f     = noise[$bits(cal_fields_type)-1:0];
      if (in_range) begin
         f.year          = (jddc_pkg::YearWidth)'($urandom_range(9999, 1));
         f.month         = (jddc_pkg::MonthWidth)'($urandom_range(12, 1));
         f.day           = (jddc_pkg::DayWidth)'($urandom_range(31, 1));
         f.hour          = (jddc_pkg::HourWidth)'($urandom_range(23, 0));
         f.minute        = (jddc_pkg::MinuteWidth)'($urandom_range(59, 0));
         f.day_number    = (jddc_pkg::DayNumWidth)'($urandom_range(5373484, 1721426));
         f.minute_of_day = (jddc_pkg::MinOfDayWidth)'($urandom_range(1439, 0));
      end
      return f;
   endfunction

   task automatic add_row(input jddc_pkg::command_type cmd, input cal_fields_type rq);
      stim_row_type row;
      row.cmd     = cmd;
      row.request = rq;
      row.pinned  = 1'b0;
      row.answer  = '0;
      directed_rows.push_back(row);
   endtask

   task automatic add_pinned(input jddc_pkg::command_type cmd, input cal_fields_type rq,
                             input cal_fields_type answer);
      stim_row_type row;
      row.cmd     = cmd;
      row.request = rq;
      row.pinned  = 1'b1;
      row.answer  = answer;
      directed_rows.push_back(row);
   endtask

   task automatic set_pace(input pace_type pace);
      case (pace)
         PaceFull: begin
            tx_idle_pct  = 0;
            rx_stall_pct = 0;
         end
         PaceSenderIdle: begin
            tx_idle_pct  = 66;
            rx_stall_pct = 0;
         end
         PaceReceiverStall: begin
            tx_idle_pct  = 0;
            rx_stall_pct = 66;
         end
         default: begin
            tx_idle_pct  = 20;
            rx_stall_pct = 20;
         end
      endcase
   endtask

   // Presents one request beat from a falling edge on and holds it until the
   // rising edge at which the unit takes it. A beat that follows directly
   // keeps tvalid high, so tvalid sees only one assignment per time step.
   task automatic send_beat(input jddc_pkg::command_type cmd, input cal_fields_type rq,
                            input bit pinned, input cal_fields_type answer);
      @(negedge clock);
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid  <= 1'b1;
      req_tuser   <= cmd;
      req_tdata   <= (jddc_pkg::DataWidth)'(rq);
      beat_pinned <= pinned;
      beat_answer <= answer;
      do @(posedge clock); while (!req_tready);
   endtask

   // The consumer side stalls on its own schedule, set by the current pace.
   always @(negedge clock) begin
      rsp_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
   end

   // Scoreboard. A request beat taken at this edge queues its expected answer;
   // a response beat taken at this edge is compared with the oldest one.
   always @(posedge clock) begin : scoreboard
      cal_fields_type seen, want;
      bit             moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            if (beat_pinned) begin
               awaited_conversions.push_back(beat_answer);
            end else begin
               awaited_conversions.push_back(convert_calendar(
                  jddc_pkg::command_type'(req_tuser[0]),
                  cal_fields_type'(req_tdata[$bits(cal_fields_type)-1:0])));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            seen  = cal_fields_type'(rsp_tdata[$bits(cal_fields_type)-1:0]);
            if (awaited_conversions.size() == 0) begin
               mismatches++;
               if (mismatches <= ReportLimit)
                  $display("[%0t] response beat with nothing outstanding: %p", $realtime, seen);
            end else begin
               want = awaited_conversions.pop_front();
               if (seen.year !== want.year || seen.month !== want.month ||
                   seen.day !== want.day || seen.hour !== want.hour ||
                   seen.minute !== want.minute || seen.day_number !== want.day_number ||
                   seen.minute_of_day !== want.minute_of_day) begin
                  mismatches++;
                  if (mismatches <= ReportLimit) begin
                     $display("[%0t] mismatch: expected y=%0d m=%0d d=%0d %0d:%0d jdn=%0d mod=%0d",
                              $realtime, want.year, want.month, want.day, want.hour,
                              want.minute, want.day_number, want.minute_of_day);
                     $display("[%0t]           actual y=%0d m=%0d d=%0d %0d:%0d jdn=%0d mod=%0d",
                              $realtime, seen.year, seen.month, seen.day, seen.hour,
                              seen.minute, seen.day_number, seen.minute_of_day);
                  end
               end
            end
         end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
   end

   // Ends the run if neither channel moves a beat for too long.
   initial begin : watchdog
      wait (idle_cycles >= StallLimit);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      stim_row_type          row;
      jddc_pkg::command_type cmd;
      int                    k;

      // Round trips of the range ends and of the J2000 epoch, answers known.
      add_pinned(jddc_pkg::CmdDateToJd, fields(2000, 1, 1, 12, 0, 0, 0),
                 fields(0, 0, 0, 0, 0, 2451545, 720));
      add_pinned(jddc_pkg::CmdDateToJd, fields(1, 1, 1, 0, 0, 0, 0),
                 fields(0, 0, 0, 0, 0, 1721426, 0));
      add_pinned(jddc_pkg::CmdDateToJd, fields(9999, 12, 31, 23, 59, 0, 0),
                 fields(0, 0, 0, 0, 0, 5373484, 1439));
      add_pinned(jddc_pkg::CmdJdToDate, fields(0, 0, 0, 0, 0, 2451545, 720),
                 fields(2000, 1, 1, 12, 0, 0, 0));
      add_pinned(jddc_pkg::CmdJdToDate, fields(0, 0, 0, 0, 0, 1721426, 0),
                 fields(1, 1, 1, 0, 0, 0, 0));
      add_pinned(jddc_pkg::CmdJdToDate, fields(0, 0, 0, 0, 0, 5373484, 1439),
                 fields(9999, 12, 31, 23, 59, 0, 0));
      // Year zero in January and February drives the shifted year negative.
      add_row(jddc_pkg::CmdDateToJd, fields(0, 1, 1, 0, 0, 0, 0));
      add_row(jddc_pkg::CmdDateToJd, fields(0, 2, 29, 6, 30, 0, 0));
      // Month zero and the months past December.
      add_row(jddc_pkg::CmdDateToJd, fields(2023, 0, 15, 8, 0, 0, 0));
      add_row(jddc_pkg::CmdDateToJd, fields(2023, 13, 1, 0, 0, 0, 0));
      add_row(jddc_pkg::CmdDateToJd, fields(2023, 14, 10, 0, 0, 0, 0));
      add_row(jddc_pkg::CmdDateToJd, fields(2023, 15, 31, 0, 0, 0, 0));
      // Dates that do not exist: February 30th and day zero.
      add_row(jddc_pkg::CmdDateToJd, fields(1999, 2, 30, 1, 1, 0, 0));
      add_row(jddc_pkg::CmdDateToJd, fields(2024, 3, 0, 12, 0, 0, 0));
      // Time of day past midnight carries into the day number.
      add_row(jddc_pkg::CmdDateToJd, fields(2024, 6, 31, 31, 63, 0, 0));
      add_row(jddc_pkg::CmdDateToJd, fields(16383, 15, 31, 31, 63, 0, 0));
      add_row(jddc_pkg::CmdDateToJd, fields(0, 0, 0, 0, 0, 0, 0));
      // Julian side: smallest and largest day numbers; the largest wraps the year.
      add_row(jddc_pkg::CmdJdToDate, fields(0, 0, 0, 0, 0, 0, 0));
      add_row(jddc_pkg::CmdJdToDate, fields(0, 0, 0, 0, 0, 8388607, 2047));
      // Minute counts of a day or more carry one day; smaller ones do not.
      add_row(jddc_pkg::CmdJdToDate, fields(0, 0, 0, 0, 0, 2451545, 1440));
      add_row(jddc_pkg::CmdJdToDate, fields(0, 0, 0, 0, 0, 2460000, 2047));
      add_row(jddc_pkg::CmdJdToDate, fields(0, 0, 0, 0, 0, 2299161, 1));
      add_row(jddc_pkg::CmdJdToDate, fields(0, 0, 0, 0, 0, 2451604, 60));
      // Fields of the other direction set to all ones must be ignored.
      add_row(jddc_pkg::CmdDateToJd, fields(2010, 7, 4, 9, 45, 8388607, 2047));
      add_row(jddc_pkg::CmdJdToDate, fields(16383, 15, 31, 31, 63, 2455000, 100));

      set_pace(PaceFull);
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < directed_rows.size(); k++) begin
         row = directed_rows[k];
         send_beat(row.cmd, row.request, row.pinned, row.answer);
      end

      // Random beats, with the pace rotating every block so that gaps and
      // stalls land on every pipeline stage and every mix of directions.
      for (k = 0; k < RandomBeats; k++) begin
         if (k % PaceBlock == 0) set_pace(pace_type'((k / PaceBlock) % 4));
         cmd = jddc_pkg::command_type'($urandom_range(1));
         send_beat(cmd, random_fields(1'($urandom_range(1))), 1'b0, '0);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      set_pace(PaceReceiverStall);

      while (awaited_conversions.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== julian_day_date_converter_unit.f =====
hdl/jddc_pkg.sv
hdl/jddc_date_to_jd.sv
hdl/jddc_jd_to_date.sv
hdl/julian_day_date_converter_unit.sv
tb/tb_julian_day_date_converter_unit.sv
